// ===== rtl/mbvs_pkg.sv =====
// Package for the memory budget victim select block: payload structs,
// request codes and default constants. No dependencies.
package mbvs_pkg;

    localparam int unsigned LIMIT_W        = 44;
    localparam int unsigned SIZE_W         = 48;
    localparam int unsigned USAGE_W        = 64;
    localparam int unsigned TIME_W         = 32;
    localparam int unsigned INDEX_W        = 8;
    localparam int unsigned MB_SHIFT       = 20;
    localparam int unsigned MAX_CAND_DEF   = 256;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 44'd4096;

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_CAND  = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [SIZE_W-1:0]  item_size;
        logic [SIZE_W-1:0]  demand_bytes;
        logic [INDEX_W-1:0] candidate_index;
        logic [TIME_W-1:0]  candidate_loaded_at;
        logic [TIME_W-1:0]  now_time;
        logic               candidate_present;
        logic               is_last;
    } t_in_item;

    typedef struct packed {
        logic [USAGE_W-1:0] ram_usage_bytes;
        logic               eviction_needed;
        logic               victim_found;
        logic [INDEX_W-1:0] victim_index;
    } t_out_item;

endpackage

// ===== rtl/memory_budget_victim_select_core.sv =====
// Top level of the memory budget victim select block.
// Depends on mbvs_pkg for payload types, request codes and defaults.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries allocate,
//   free and eviction candidate items. A transfer happens when valid is
//   high and stall is low. Allocate and free each return one result with
//   the updated usage counter. Candidates of an eviction query return
//   nothing until the one marked is_last, which returns the verdict: whether
//   eviction is needed and the oldest fitting candidate, if any.
//   Output channel (o_out_valid / i_out_stall / o_out_item) holds a result
//   until the receiver takes it.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the RAM
//   budget in MB; it is always ready, and it must be written only while idle, which the block does not enforce.
// Pipeline:
//   One item per cycle sustained while the output is not stalled. An item
//   is captured in the input register, is evaluated against the counters
//   there, and its result is loaded into the output register, which drives
//   o_out_valid. The throughput is set by the single evaluation stage, which
//   updates the counters in the same cycle it reads them.
// Reset clears the counters, the open query and both valid flags, and sets
// the budget to 4096 MB. While the output holds a result, an item that returns a
// result waits in the input register and the input stalls; other items pass.
module memory_budget_victim_select_core #(
    parameter int unsigned MAX_CANDIDATES = mbvs_pkg::MAX_CAND_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  mbvs_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output mbvs_pkg::t_out_item           o_out_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mbvs_pkg::LIMIT_W-1:0]  i_cfg_data
);

    localparam int unsigned CNT_W = $clog2(MAX_CANDIDATES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CANDIDATES);
    localparam int unsigned UW = mbvs_pkg::USAGE_W;

    // registers
    logic [mbvs_pkg::LIMIT_W-1:0] r_limit_mb;
    logic [UW-1:0]                r_usage,      n_usage;
    logic [mbvs_pkg::TIME_W-1:0]  r_best_time,  n_best_time;
    logic [mbvs_pkg::INDEX_W-1:0] r_best_index, n_best_index;
    logic                         r_best_valid, n_best_valid;
    logic                         r_in_query,   n_in_query;
    logic [CNT_W-1:0]             r_cand_count, n_cand_count;
    logic                         r_in_valid;
    mbvs_pkg::t_in_item           r_in;
    logic                         r_out_valid;
    mbvs_pkg::t_out_item          r_out, n_out;

    // evaluation stage
    logic           out_free;
    logic           has_result;
    logic           advance;
    logic [UW-1:0]  limit_bytes;
    logic [UW:0]    avail_diff;
    logic [UW-1:0]  avail;
    logic           needed;
    logic [UW:0]    fit_sum;
    logic           fits;
    logic [UW:0]    add_sum;
    logic [mbvs_pkg::TIME_W-1:0]  cur_best_time;
    logic [mbvs_pkg::INDEX_W-1:0] cur_best_index;
    logic                         cur_best_valid;
    logic [CNT_W-1:0]             cur_count;
    logic                         take;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign has_result  = (r_in.req_type == mbvs_pkg::REQ_ALLOC)
                      || (r_in.req_type == mbvs_pkg::REQ_FREE)
                      || ((r_in.req_type == mbvs_pkg::REQ_CAND) && r_in.is_last);
    assign advance     = r_in_valid && (!has_result || out_free);
    assign o_in_stall  = r_in_valid && !advance;

    assign limit_bytes = {r_limit_mb, {mbvs_pkg::MB_SHIFT{1'b0}}};
    assign avail_diff  = {1'b0, limit_bytes} - {1'b0, r_usage};
    assign avail       = avail_diff[UW] ? '0 : avail_diff[UW-1:0];
    assign needed      = {{(UW - mbvs_pkg::SIZE_W){1'b0}}, r_in.demand_bytes} > avail;
    // size >= req - avail, written as a sum so no subtract chains behind avail
    assign fit_sum     = {1'b0, avail} + {{(UW + 1 - mbvs_pkg::SIZE_W){1'b0}}, r_in.item_size};
    assign fits        = fit_sum >= {{(UW + 1 - mbvs_pkg::SIZE_W){1'b0}}, r_in.demand_bytes};
    assign add_sum     = {1'b0, r_usage} + {{(UW + 1 - mbvs_pkg::SIZE_W){1'b0}}, r_in.item_size};

    always_comb begin
        // first candidate of a query opens it with a fresh bound
        if (r_in_query) begin
            cur_best_time  = r_best_time;
            cur_best_index = r_best_index;
            cur_best_valid = r_best_valid;
            cur_count      = r_cand_count;
        end else begin
            cur_best_time  = r_in.now_time;
            cur_best_index = '0;
            cur_best_valid = 1'b0;
            cur_count      = '0;
        end
        take = r_in.candidate_present && (cur_count < CNT_MAX) && needed && fits
            && (r_in.candidate_loaded_at < cur_best_time);

        n_usage      = r_usage;
        n_best_time  = r_best_time;
        n_best_index = r_best_index;
        n_best_valid = r_best_valid;
        n_in_query   = r_in_query;
        n_cand_count = r_cand_count;
        n_out.ram_usage_bytes = r_usage;
        n_out.eviction_needed = 1'b0;
        n_out.victim_found    = 1'b0;
        n_out.victim_index    = '0;

        case (r_in.req_type)
            mbvs_pkg::REQ_ALLOC: begin
                n_usage = add_sum[UW] ? '1 : add_sum[UW-1:0];
                n_out.ram_usage_bytes = n_usage;
            end
            mbvs_pkg::REQ_FREE: begin
                n_usage = (r_usage >= {{(UW - mbvs_pkg::SIZE_W){1'b0}}, r_in.item_size})
                        ? r_usage - {{(UW - mbvs_pkg::SIZE_W){1'b0}}, r_in.item_size}
                        : '0;
                n_out.ram_usage_bytes = n_usage;
            end
            mbvs_pkg::REQ_CAND: begin
                n_best_time  = take ? r_in.candidate_loaded_at : cur_best_time;
                n_best_index = take ? r_in.candidate_index     : cur_best_index;
                n_best_valid = take || cur_best_valid;
                n_cand_count = (r_in.candidate_present && (cur_count < CNT_MAX))
                             ? cur_count + 1'b1 : cur_count;
                n_in_query   = 1'b1;
                n_out.eviction_needed = needed;
                n_out.victim_found    = needed && n_best_valid;
                n_out.victim_index    = (needed && n_best_valid) ? n_best_index : '0;
                if (r_in.is_last) begin
                    // query closes; clear so the next one starts clean
                    n_in_query   = 1'b0;
                    n_best_valid = 1'b0;
                    n_cand_count = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_mb   <= mbvs_pkg::LIMIT_RESET;
            r_usage      <= '0;
            r_best_time  <= '0;
            r_best_index <= '0;
            r_best_valid <= 1'b0;
            r_in_query   <= 1'b0;
            r_cand_count <= '0;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit_mb <= i_cfg_data;
            end
            if (advance) begin
                r_usage      <= n_usage;
                r_best_time  <= n_best_time;
                r_best_index <= n_best_index;
                r_best_valid <= n_best_valid;
                r_in_query   <= n_in_query;
                r_cand_count <= n_cand_count;
            end
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance && has_result) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_item;
        end
        if (advance && has_result) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // a chosen victim only exists while a query is open
    a_best_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best_valid |-> r_in_query)
        else $error("best candidate held outside a query");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cand_count <= CNT_MAX)
        else $error("candidate count past limit");

    a_victim_needs_eviction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.victim_found) |-> o_out_item.eviction_needed)
        else $error("victim reported without eviction");

    a_no_victim_zero_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.victim_found) |-> (o_out_item.victim_index == '0))
        else $error("victim index set without victim");

    a_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !(advance && has_result))
        else $error("pending result overwritten");

endmodule

// ===== tb/mbvs_checker.sv =====
// Scoreboard for memory_budget_victim_select_core: watches the input, output and
// config channels, tracks usage and the open eviction query, and checks each result.
// Depends on mbvs_pkg for payload types, request codes and widths.
module mbvs_checker #(
    parameter int unsigned MAX_CANDIDATES = mbvs_pkg::MAX_CAND_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  mbvs_pkg::t_in_item            i_in_item,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  mbvs_pkg::t_out_item           i_out_item,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [mbvs_pkg::LIMIT_W-1:0]  i_cfg_data,
    output int                            o_pending,
    output int                            o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned UW = mbvs_pkg::USAGE_W;

    logic [mbvs_pkg::LIMIT_W-1:0] budget_mb;
    logic [UW-1:0]                usage;
    logic [mbvs_pkg::TIME_W-1:0]  bound_stamp;
    logic [mbvs_pkg::INDEX_W-1:0] victim_idx;
    logic                         victim_ok;
    logic                         query_open;
    int unsigned                  cand_seen;
    mbvs_pkg::t_out_item          verdicts[$];
    int                           fails = 0;

    always @(posedge i_clk) begin
        mbvs_pkg::t_out_item want;
        mbvs_pkg::t_out_item got;
        mbvs_pkg::t_in_item  it;
        logic [UW:0]         sum;
        logic [UW-1:0]       budget_bytes;
        logic [UW-1:0]       room;
        logic                tight;
        if (!i_rst_n) begin
            budget_mb   = mbvs_pkg::LIMIT_RESET;
            usage       = '0;
            bound_stamp = '0;
            victim_idx  = '0;
            victim_ok   = 1'b0;
            query_open  = 1'b0;
            cand_seen   = 0;
            verdicts.delete();
        end else begin
            // results leave only after their item has entered, so compare before predicting
            if (i_out_valid && !i_out_stall) begin
                got = i_out_item;
                if (verdicts.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: unexpected result: usage %0h needed %0b found %0b idx %0d",
                                 $realtime, got.ram_usage_bytes, got.eviction_needed,
                                 got.victim_found, got.victim_index);
                end else begin
                    want = verdicts.pop_front();
                    if (got.ram_usage_bytes !== want.ram_usage_bytes ||
                        got.eviction_needed !== want.eviction_needed ||
                        got.victim_found !== want.victim_found ||
                        got.victim_index !== want.victim_index) begin
                        fails++;
                        if (fails <= 10)
                            $display("%0t: result mismatch: usage exp %0h got %0h, %s %0b/%0b, %s",
                                     $realtime, want.ram_usage_bytes, got.ram_usage_bytes,
                                     "needed exp/got", want.eviction_needed,
                                     got.eviction_needed,
                                     $sformatf("found %0b/%0b, index %0d/%0d",
                                               want.victim_found, got.victim_found,
                                               want.victim_index, got.victim_index));
                    end
                end
            end

            if (i_cfg_valid && i_cfg_ready)
                budget_mb = i_cfg_data;

            if (i_in_valid && !i_in_stall) begin
                it   = i_in_item;
                want = '0;
                case (it.req_type)
                    mbvs_pkg::REQ_ALLOC: begin
                        sum   = {1'b0, usage} + (UW+1)'(it.item_size);
                        usage = sum[UW] ? '1 : sum[UW-1:0];
                        want.ram_usage_bytes = usage;
                        verdicts.push_back(want);
                    end
                    mbvs_pkg::REQ_FREE: begin
                        usage = (usage >= UW'(it.item_size)) ?
                                usage - UW'(it.item_size) : '0;
                        want.ram_usage_bytes = usage;
                        verdicts.push_back(want);
                    end
                    mbvs_pkg::REQ_CAND: begin
                        if (!query_open) begin
                            query_open  = 1'b1;
                            bound_stamp = it.now_time;
                            victim_idx  = '0;
                            victim_ok   = 1'b0;
                            cand_seen   = 0;
                        end
                        budget_bytes = UW'(budget_mb) << mbvs_pkg::MB_SHIFT;
                        room  = (budget_bytes > usage) ? budget_bytes - usage : '0;
                        tight = UW'(it.demand_bytes) > room;
                        if (it.candidate_present && cand_seen < MAX_CANDIDATES) begin
                            cand_seen++;
                            // ties on load time keep the earlier candidate
                            if (tight &&
                                UW'(it.item_size) >= UW'(it.demand_bytes) - room &&
                                it.candidate_loaded_at < bound_stamp) begin
                                bound_stamp = it.candidate_loaded_at;
                                victim_idx  = it.candidate_index;
                                victim_ok   = 1'b1;
                            end
                        end
                        if (it.is_last) begin
                            query_open           = 1'b0;
                            want.ram_usage_bytes = usage;
                            want.eviction_needed = tight;
                            want.victim_found    = tight && victim_ok;
                            want.victim_index    = (tight && victim_ok) ? victim_idx : '0;
                            verdicts.push_back(want);
                        end
                    end
                    default: ;  // spare request code: no effect
                endcase
            end
        end
        o_pending    <= verdicts.size();
        o_fail_count <= fails;
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the memory_budget_victim_select_core testbench: clock, reset, stimulus
// and verdict. Depends on mbvs_pkg, the core and mbvs_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REQ_SPARE    = 2'd3;
    localparam int         MAX_CAND     = mbvs_pkg::MAX_CAND_DEF;
    localparam int         DRAIN_CYCLES = 4;
    localparam int         LONG_HOLD    = 300;
    localparam int unsigned SW          = mbvs_pkg::SIZE_W;
    localparam int unsigned TW          = mbvs_pkg::TIME_W;
    localparam int unsigned IW          = mbvs_pkg::INDEX_W;
    localparam int unsigned LW          = mbvs_pkg::LIMIT_W;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    mbvs_pkg::t_in_item   in_item = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    mbvs_pkg::t_out_item  out_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [LW-1:0]        cfg_data = '0;
    int                   pending;
    int                   fail_count;

    bit                   tx_steady = 1'b0;
    bit                   hold_req = 1'b0;
    bit                   query_open = 1'b0;
    int                   sent = 0;
    logic [63:0]          scale = 64'd1 << 33;

    memory_budget_victim_select_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    mbvs_checker #(.MAX_CANDIDATES(MAX_CAND)) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #8_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side: random stalls, calm stretches, and one long hold-off on request
    initial begin
        int  wait_cycles;
        int  taken;
        bit  calm;
        taken = 0;
        calm  = 1'b0;
        forever begin
            if (taken % 40 == 0)
                calm = ($urandom_range(0, 2) == 0);
            if (hold_req) begin
                wait_cycles = LONG_HOLD;
                hold_req    = 1'b0;
            end else begin
                wait_cycles = calm ? 0 : $urandom_range(0, 19);
            end
            if (wait_cycles > 0) begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    function automatic mbvs_pkg::t_in_item make_ctl(input logic [1:0] kind,
                                                    input logic [SW-1:0] size);
        mbvs_pkg::t_in_item it;
        it           = '0;
        it.req_type  = kind;
        it.item_size = size;
        return it;
    endfunction

    function automatic mbvs_pkg::t_in_item make_cand(input logic [IW-1:0] idx,
                                                     input logic [SW-1:0] size,
                                                     input logic [SW-1:0] need,
                                                     input logic [TW-1:0] loaded_at,
                                                     input logic [TW-1:0] now,
                                                     input logic present, input logic last);
        mbvs_pkg::t_in_item it;
        it.req_type            = mbvs_pkg::REQ_CAND;
        it.item_size           = size;
        it.demand_bytes        = need;
        it.candidate_index     = idx;
        it.candidate_loaded_at = loaded_at;
        it.now_time            = now;
        it.candidate_present   = present;
        it.is_last             = last;
        return it;
    endfunction

    function automatic mbvs_pkg::t_in_item make_noise();
        logic [191:0] bits;
        bits = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        return bits[$bits(mbvs_pkg::t_in_item)-1:0];
    endfunction

    // sizes mostly on the scale of the current budget, with the edges mixed in
    function automatic logic [SW-1:0] rnd_size();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            2:       return r[SW-1:0];
            default: return SW'(r % (scale + 64'd1));
        endcase
    endfunction

    task automatic send(input mbvs_pkg::t_in_item it);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        if (it.req_type == mbvs_pkg::REQ_CAND)
            query_open = !it.is_last;
        if (it.req_type != REQ_SPARE)
            sent++;
    endtask

    // close any open query, then wait for every result plus the pipeline tail
    task automatic settle();
        if (query_open)
            send(make_cand('0, '0, rnd_size(), '0, '0, 1'b0, 1'b1));
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LW-1:0] mb);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= mb;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (mb == '0)
            scale = 64'd1 << 24;
        else if (mb > (LW'(1) << 26))
            scale = 64'd1 << 46;
        else
            scale = (64'(mb) << mbvs_pkg::MB_SHIFT) << 1;
    endtask

    task automatic run_query();
        int             n;
        bit             broken;
        bit             longq;
        logic [SW-1:0]  need;
        logic [SW-1:0]  size;
        logic [TW-1:0]  now;
        logic [TW-1:0]  loaded_at;
        logic [IW-1:0]  idx;
        logic           present;
        logic           last;
        longq  = ($urandom_range(0, 59) == 0);
        broken = ($urandom_range(0, 7) == 0);
        n      = longq ? MAX_CAND + $urandom_range(1, 6) : $urandom_range(1, 8);
        need   = rnd_size();
        case ($urandom_range(0, 9))
            0:       now = '0;
            1:       now = '1;
            default: now = $urandom();
        endcase
        if (longq)
            now = now | 32'd1;
        for (int k = 0; k < n; k++) begin
            if (broken && $urandom_range(0, 3) == 0)
                send(make_ctl($urandom_range(0, 1) ? mbvs_pkg::REQ_ALLOC : mbvs_pkg::REQ_FREE,
                              rnd_size()));
            case ($urandom_range(0, 9))
                0:       loaded_at = $urandom();
                1:       loaded_at = now;
                2:       loaded_at = now + 32'd1;
                default: loaded_at = now - TW'($urandom_range(1, 4));
            endcase
            size    = rnd_size();
            idx     = $urandom_range(0, 255);
            present = ($urandom_range(0, 9) != 0);
            if (longq) begin
                idx     = IW'(k);
                present = 1'b1;
                // past the candidate cap: oldest and big enough, yet must be ignored
                if (k >= MAX_CAND) begin
                    size      = '1;
                    loaded_at = '0;
                end
            end
            last = (k == n - 1) && !(broken && $urandom_range(0, 3) == 0);
            send(make_cand(idx, size,
                           (broken && $urandom_range(0, 2) == 0) ? rnd_size() : need,
                           loaded_at, (k == 0) ? now : TW'($urandom()),
                           present, last));
        end
    endtask

    task automatic run_phase(input int quota, input bit steady);
        int goal;
        tx_steady = steady;
        goal      = sent + quota;
        while (sent < goal) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3: send(make_ctl(mbvs_pkg::REQ_ALLOC, rnd_size()));
                4, 5, 6, 7: send(make_ctl(mbvs_pkg::REQ_FREE, rnd_size()));
                8:          send(make_ctl(REQ_SPARE, '0) | make_noise() | {2'b11, 170'd0});
                9:          send(make_noise());
                default:    run_query();
            endcase
        end
        tx_steady = 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset budget of 4096 MB, i.e. 2**32 bytes
        send(make_ctl(mbvs_pkg::REQ_ALLOC, '0));
        send(make_ctl(mbvs_pkg::REQ_FREE, 48'd7));                     // clamps at zero
        send(make_ctl(mbvs_pkg::REQ_ALLOC, 48'hFFFF_FFFF - 48'd99));   // 100 bytes left
        send(make_cand(8'd0, 48'd1, 48'd50, 32'd1, 32'd9, 1'b1, 1'b1));   // fits already
        send(make_cand(8'd1, 48'd899, 48'd1000, 32'd10, 32'd1000, 1'b1, 1'b0));
        send(make_cand(8'd2, 48'd900, 48'd1000, 32'd500, 32'd3, 1'b1, 1'b0));
        send(make_cand(8'd3, 48'd2000, 48'd1000, 32'd500, 32'd3, 1'b1, 1'b0));  // tie
        send(make_cand(8'd4, '1, 48'd1000, 32'd1000, 32'd3, 1'b1, 1'b1));  // not before now
        send(make_cand(8'd5, '1, 48'd1000, '0, 32'd50, 1'b0, 1'b1));      // empty list
        send(make_cand(8'd255, '1, '1, '0, '0, 1'b1, 1'b1));              // nothing before 0
        send(make_cand(8'd255, '1, '1, 32'hFFFF_FFFE, '1, 1'b1, 1'b1));
        send(make_ctl(REQ_SPARE, '1) | make_noise());                     // ignored
        send(make_cand(8'd7, 48'd5000, 48'd2000, 32'd5, 32'd80, 1'b1, 1'b0));
        send(make_ctl(mbvs_pkg::REQ_ALLOC, '0));                          // query stays open
        send(make_cand(8'd8, 48'd5000, 48'd2000, 32'd1, 32'd0, 1'b0, 1'b1));
        send(make_ctl(mbvs_pkg::REQ_ALLOC, '1));
        send(make_ctl(mbvs_pkg::REQ_FREE, '1));
        send(make_ctl(mbvs_pkg::REQ_FREE, 48'h1_0000_0000));
        settle();

        write_limit('0);
        run_phase(150, 1'b0);
        write_limit('1);
        run_phase(150, 1'b0);
        write_limit(mbvs_pkg::LIMIT_RESET);
        hold_req = 1'b1;
        run_phase(200, 1'b1);
        settle();                                  // sender pauses until all results are in
        write_limit(44'd1);
        run_phase(170, 1'b0);
        write_limit(LW'($urandom_range(1, 64)));
        run_phase(170, $urandom_range(0, 1));
        write_limit(LW'({$urandom(), $urandom()}));
        run_phase(170, 1'b0);
        write_limit(LW'($urandom_range(1, 1024)));
        run_phase(170, $urandom_range(0, 1));
        write_limit(LW'($urandom_range(1, 16)));
        run_phase(170, 1'b0);
        write_limit(mbvs_pkg::LIMIT_RESET);
        run_phase(170, 1'b0);
        settle();

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mbvs_pkg.sv
rtl/memory_budget_victim_select_core.sv
tb/mbvs_checker.sv
tb/tb_top.sv
